// File: src/pchs_pkg.sv
// Shared types, constants and the hue weight function for the pixel colorize block.
`default_nettype none
package pchs_pkg;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_KEEP_SAT = 2'd0;
  localparam logic [1:0] REG_HUE      = 2'd1;
  localparam logic [1:0] REG_SAT      = 2'd2;

  localparam logic [12:0] HUE_FULL   = 13'd5760;
  localparam logic [12:0] HUE_THIRD  = 13'd1920;
  localparam logic [12:0] HUE_SIXTH  = 13'd960;
  localparam logic [12:0] HUE_HALF   = 13'd2880;
  localparam logic [12:0] HUE_FALL   = 13'd3840;
  localparam logic [12:0] W_ONE      = 13'd4096;
  localparam logic [8:0]  SAT_ONE    = 9'd256;
  localparam logic [8:0]  NL_FULL    = 9'd510;
  // ceil(2^20 / 15): floor(hh*64/15) == (hh*RECIP15) >> 14 for hh <= 960
  localparam logic [16:0] RECIP15    = 17'd69906;

  typedef struct packed {
    logic [7:0] in_alpha;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_alpha;
    logic [7:0] out_high_byte;
    logic [7:0] out_mid_byte;
    logic [7:0] out_low_byte;
  } pixel_out_t;

  // Settings seen by the pixel pipeline; w[0] low, w[1] mid, w[2] high channel
  typedef struct packed {
    logic             keep_sat;
    logic [8:0]       sat;
    logic [2:0][12:0] w;
  } cfg_t;

  // Q12 weight of one HLS hue segment position, hh in 1/16 degree below HUE_FULL
  function automatic logic [12:0] hue_weight(input logic [12:0] hh);
    logic [12:0] fall_off;
    logic [26:0] prod;
    logic [12:0] res;
    fall_off = HUE_FALL - hh;
    prod = '0;
    if (hh < HUE_SIXTH) begin
      prod = 27'(hh[9:0] * RECIP15);
      res  = prod[26:14];
    end else if (hh < HUE_HALF) begin
      res = W_ONE;
    end else if (hh < HUE_FALL) begin
      prod = 27'(fall_off[9:0] * RECIP15);
      res  = prod[26:14];
    end else begin
      res = '0;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: src/pixel_colorize_hls_unit.sv
// Top level of the HLS colorize pixel pipeline.
//
//  channel   ports                               direction  width
//  request   start, busy, in_pixel               in         32 bit pixel
//  result    out_strobe, out_pixel               out        32 bit pixel
//  config    psel/penable/pwrite/paddr/pwdata    in/out     32 bit data, 4 bit addr
//
//  One pixel per cycle; busy is always low. A pixel taken with start passes the six
//  register stages (min/max, saturation multiply, weight multiply, sum, blend multiply,
//  sum) on its way to out_strobe. The ratio divider runs in three of these stages
//  alongside the color path. Synchronous reset clears the valid bits and the
//  configuration registers; the data registers are not reset. Results cannot be
//  held off.
`default_nettype none
module pixel_colorize_hls_unit
  import pchs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire pixel_in_t         in_pixel,
  output logic                   out_strobe,
  output pixel_out_t             out_pixel,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;

  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r, out_valid_r;

  logic [7:0] s1_l_r, s1_d_r, s1_div_r, s1_alpha_r;
  logic [7:0] s2_l_r, s2_alpha_r;
  logic [14:0] s2_x_r;
  logic s2_dz_r, s3_dz_r, s4_dz_r;
  logic [7:0] s3_l_r, s3_alpha_r;
  logic [15:0] s3_m1_r;
  logic [2:0][28:0] s3_prod_r;
  logic [7:0] s4_l_r, s4_alpha_r;
  logic [2:0][7:0] s4_c_r;
  logic [7:0] s5_alpha_r;
  logic [2:0][16:0] s5_pc_r;
  logic [16:0] s5_pl_r;
  pixel_out_t out_pixel_r;

  logic [7:0] mx, mn, div_nxt;
  logic [8:0] nl, div_full;
  logic [7:0] mop;
  logic [16:0] x_full;
  logic [15:0] diff;
  logic [15:0] m1_nxt;
  logic [2:0][28:0] prod_nxt;
  logic [2:0][7:0] c_nxt;
  logic [29:0] acc;
  logic [8:0] q, ns, ns_inv;
  logic [2:0][16:0] pc_nxt;
  logic [16:0] pl_nxt;
  logic [17:0] bsum;
  pixel_out_t out_nxt;
  logic accept;

  pchs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pchs_div u_div (
    .clk  (clk),
    .num  (s1_d_r),
    .den  (s1_div_r),
    .quot (q)
  );

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 1: extremes, lightness, saturation divisor
  always_comb begin
    mx = (in_pixel.in_red > in_pixel.in_green) ? in_pixel.in_red : in_pixel.in_green;
    mn = (in_pixel.in_red > in_pixel.in_green) ? in_pixel.in_green : in_pixel.in_red;
    if (in_pixel.in_blue > mx) mx = in_pixel.in_blue;
    if (in_pixel.in_blue < mn) mn = in_pixel.in_blue;
    nl       = {1'b0, mx} + {1'b0, mn};
    div_full = nl[8] ? NL_FULL - nl : nl;
    div_nxt  = div_full[7:0];
  end

  // Stage 2: x = s*l or s*(255-l); M2 = 256l + x, M1 = 256l - x
  always_comb begin
    mop    = s1_l_r[7] ? 8'd255 - s1_l_r : s1_l_r;
    x_full = 17'(mop * cfg.sat);
  end

  // Stage 3: (M2 - M1) * w per channel
  always_comb begin
    diff   = {s2_x_r, 1'b0};
    m1_nxt = {s2_l_r, 8'h00} - {1'b0, s2_x_r};
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = 29'(diff * cfg.w[i]);
    end
  end

  // Stage 4: byte = (4096*M1 + prod) >> 20
  always_comb begin
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      acc      = {2'b00, s3_m1_r, 12'h000} + {1'b0, s3_prod_r[i]};
      c_nxt[i] = acc[27:20];
    end
  end

  // Stage 5: blend toward grey; mode 0 uses a full ratio, grey pixels a zero ratio
  always_comb begin
    if (!cfg.keep_sat) begin
      ns = SAT_ONE;
    end else if (s4_dz_r) begin
      ns = '0;
    end else begin
      ns = (q > SAT_ONE) ? SAT_ONE : q;
    end
    ns_inv = SAT_ONE - ns;
    pl_nxt = 17'(s4_l_r * ns_inv);
    for (int i = 0; i < 3; i++) begin
      pc_nxt[i] = 17'(s4_c_r[i] * ns);
    end
  end

  // Stage 6: sum and drop the Q8 fraction
  always_comb begin
    bsum = '0;
    out_nxt.out_alpha = s5_alpha_r;
    bsum = {1'b0, s5_pc_r[0]} + {1'b0, s5_pl_r};
    out_nxt.out_low_byte = bsum[15:8];
    bsum = {1'b0, s5_pc_r[1]} + {1'b0, s5_pl_r};
    out_nxt.out_mid_byte = bsum[15:8];
    bsum = {1'b0, s5_pc_r[2]} + {1'b0, s5_pl_r};
    out_nxt.out_high_byte = bsum[15:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      out_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_l_r     <= nl[8:1];
    s1_d_r     <= mx - mn;
    s1_div_r   <= div_nxt;
    s1_alpha_r <= in_pixel.in_alpha;

    s2_x_r     <= x_full[14:0];
    s2_l_r     <= s1_l_r;
    s2_dz_r    <= (s1_d_r == 8'd0);
    s2_alpha_r <= s1_alpha_r;

    s3_prod_r  <= prod_nxt;
    s3_m1_r    <= m1_nxt;
    s3_l_r     <= s2_l_r;
    s3_dz_r    <= s2_dz_r;
    s3_alpha_r <= s2_alpha_r;

    s4_c_r     <= c_nxt;
    s4_l_r     <= s3_l_r;
    s4_dz_r    <= s3_dz_r;
    s4_alpha_r <= s3_alpha_r;

    s5_pc_r    <= pc_nxt;
    s5_pl_r    <= pl_nxt;
    s5_alpha_r <= s4_alpha_r;

    out_pixel_r <= out_nxt;
  end

  assign out_strobe = out_valid_r;
  assign out_pixel  = out_pixel_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##6 out_strobe)
    else $error("request did not produce a result six cycles later");

  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_pixel.out_alpha == $past(in_pixel.in_alpha, 6))
    else $error("alpha not carried with its pixel");

  a_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_valid_r && !s4_dz_r) |-> q <= SAT_ONE)
    else $error("saturation ratio above one");

endmodule
`default_nettype wire

// File: src/pchs_cfg.sv
// Configuration registers on the APB port and the hue weights derived from them.
`default_nettype none
module pchs_cfg
  import pchs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic             keep_r;
  logic [12:0]      hue_r;
  logic [8:0]       sat_r;
  logic [8:0]       sat_eff_r;
  logic [2:0][12:0] hh_r;
  logic [2:0][12:0] w_r;
  logic [2:0][12:0] hh_nxt;
  logic [12:0]      hue_mod;
  logic [12:0]      hue_hi;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= 1'b0;
      hue_r  <= '0;
      sat_r  <= SAT_ONE;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEEP_SAT: keep_r <= pwdata[0];
        REG_HUE:      hue_r  <= pwdata[12:0];
        REG_SAT:      sat_r  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEEP_SAT: prdata = CFG_DW'(keep_r);
      REG_HUE:      prdata = CFG_DW'(hue_r);
      REG_SAT:      prdata = CFG_DW'(sat_r);
      default:      prdata = '0;
    endcase
  end

  // Hue positions of the three channels, 120 degrees apart
  always_comb begin
    hue_mod   = (hue_r >= HUE_FULL) ? hue_r - HUE_FULL : hue_r;
    hue_hi    = hue_mod + HUE_THIRD;
    hh_nxt[1] = hue_mod;
    hh_nxt[0] = (hue_mod >= HUE_THIRD) ? hue_mod - HUE_THIRD : hue_mod + (HUE_FULL - HUE_THIRD);
    hh_nxt[2] = (hue_hi >= HUE_FULL) ? hue_hi - HUE_FULL : hue_hi;
  end

  // Derived values track the registers every cycle: sat_eff_r is registered from sat_r, the weights pass hh_r then w_r
  always_ff @(posedge clk) begin
    sat_eff_r <= (sat_r > SAT_ONE) ? SAT_ONE : sat_r;
    hh_r      <= hh_nxt;
    for (int i = 0; i < 3; i++) begin
      w_r[i] <= hue_weight(hh_r[i]);
    end
  end

  assign cfg.keep_sat = keep_r;
  assign cfg.sat      = sat_eff_r;
  assign cfg.w        = w_r;

endmodule
`default_nettype wire

// File: src/pchs_div.sv
// Pipelined restoring divider for the saturation ratio (d << 8) / div, three bits per stage.
`default_nettype none
module pchs_div
  import pchs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic [7:0] num,
  input  wire logic [7:0] den,
  output logic      [8:0] quot
);

  logic [7:0] rem1_r, rem2_r;
  logic [7:0] den1_r, den2_r;
  logic [2:0] q1_r;
  logic [5:0] q2_r;
  logic [8:0] q3_r;

  logic [7:0] rem1_nxt, rem2_nxt;
  logic [2:0] q1_nxt;
  logic [5:0] q2_nxt;
  logic [8:0] q3_nxt;

  // One shift-compare-subtract step: returns {quotient bit, new remainder}
  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic [7:0] d);
    logic [8:0] t;
    logic [8:0] diff;
    t    = {rem, 1'b0};
    diff = t - {1'b0, d};
    return (t >= {1'b0, d}) ? {1'b1, diff[7:0]} : {1'b0, t[7:0]};
  endfunction

  always_comb begin
    logic [8:0] st;
    logic [7:0] r;
    // Top quotient bit: the numerator never exceeds the divisor
    q1_nxt[2] = (num >= den);
    r         = q1_nxt[2] ? num - den : num;
    for (int i = 1; i >= 0; i--) begin
      st        = div_step(r, den);
      q1_nxt[i] = st[8];
      r         = st[7:0];
    end
    rem1_nxt = r;

    r = rem1_r;
    q2_nxt[5:3] = q1_r;
    for (int i = 2; i >= 0; i--) begin
      st        = div_step(r, den1_r);
      q2_nxt[i] = st[8];
      r         = st[7:0];
    end
    rem2_nxt = r;

    r = rem2_r;
    q3_nxt[8:3] = q2_r;
    for (int i = 2; i >= 0; i--) begin
      st        = div_step(r, den2_r);
      q3_nxt[i] = st[8];
      r         = st[7:0];
    end
  end

  always_ff @(posedge clk) begin
    rem1_r <= rem1_nxt;
    den1_r <= den;
    q1_r   <= q1_nxt;
    rem2_r <= rem2_nxt;
    den2_r <= den1_r;
    q2_r   <= q2_nxt;
    q3_r   <= q3_nxt;
  end

  assign quot = q3_r;

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for pixel_colorize_hls_unit: corner and random pixels, table and random settings.
`timescale 1ns / 1ps

module tb;
  import pchs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 16;
  localparam int PIXELS_PER_PHASE = 86;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Expected pixels from a bit-exact colorize predictor, checked in order.
  class colorize_scoreboard;
    logic keep_sat;
    logic [12:0] hue_reg;
    logic [8:0] sat_reg;
    pixel_out_t expected_px_q[$];
    int errors;
    int requests;
    int checked;

    function new();
      keep_sat = 1'b0;
      hue_reg = '0;
      sat_reg = SAT_ONE;
      errors = 0;
      requests = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      unique case (idx)
        REG_KEEP_SAT: keep_sat = value[0];
        REG_HUE:      hue_reg = value[12:0];
        REG_SAT:      sat_reg = value[8:0];
        default: ;
      endcase
    endfunction

    function void note_request(pixel_in_t px);
      int unsigned r, g, b, mx, mn, nl, d, l, s, hue, m1, m2, hh, w, ns, dv, c;
      int unsigned offs [3];
      longint unsigned acc;
      logic [7:0] ch [3];
      pixel_out_t exp_px;
      r = px.in_red;
      g = px.in_green;
      b = px.in_blue;
      mx = (r > g) ? r : g;
      mn = (r > g) ? g : r;
      if (b > mx) mx = b;
      if (b < mn) mn = b;
      nl = mx + mn;
      d = mx - mn;
      l = nl >> 1;
      s = (sat_reg > SAT_ONE) ? SAT_ONE : sat_reg;
      hue = hue_reg % HUE_FULL;
      m2 = 256 * l + ((l < 128) ? l * s : s * (255 - l));
      m1 = 512 * l - m2;
      offs[0] = HUE_FULL - HUE_THIRD;
      offs[1] = 0;
      offs[2] = HUE_THIRD;
      ns = 256;
      if (d != 0) begin
        dv = (nl <= 255) ? nl : NL_FULL - nl;
        ns = (d << 8) / dv;
        if (ns > 256) ns = 256;
      end
      for (int i = 0; i < 3; i++) begin
        hh = (hue + offs[i]) % HUE_FULL;
        if (hh < HUE_SIXTH) w = (hh * W_ONE) / HUE_SIXTH;
        else if (hh < HUE_HALF) w = W_ONE;
        else if (hh < HUE_FALL) w = ((HUE_FALL - hh) * W_ONE) / HUE_SIXTH;
        else w = 0;
        acc = longint'(W_ONE) * m1 + longint'(m2 - m1) * w;
        c = 32'((acc >> 20) & 64'hff);
        // blend toward grey by the source saturation
        if (keep_sat) c = (d == 0) ? l : (((c * ns + l * (256 - ns)) >> 8) & 32'hff);
        ch[i] = c[7:0];
      end
      exp_px.out_low_byte = ch[0];
      exp_px.out_mid_byte = ch[1];
      exp_px.out_high_byte = ch[2];
      exp_px.out_alpha = px.in_alpha;
      expected_px_q.push_back(exp_px);
      requests++;
    endfunction

    function void check_result(pixel_out_t got);
      pixel_out_t want;
      if (expected_px_q.size() == 0) begin
        $display("%0t: result %h with no request pending", $time, got);
        errors++;
        return;
      end
      want = expected_px_q.pop_front();
      checked++;
      if (got.out_low_byte !== want.out_low_byte) begin
        $display("%0t: out_low_byte expected %h actual %h", $time,
                 want.out_low_byte, got.out_low_byte);
        errors++;
      end
      if (got.out_mid_byte !== want.out_mid_byte) begin
        $display("%0t: out_mid_byte expected %h actual %h", $time,
                 want.out_mid_byte, got.out_mid_byte);
        errors++;
      end
      if (got.out_high_byte !== want.out_high_byte) begin
        $display("%0t: out_high_byte expected %h actual %h", $time,
                 want.out_high_byte, got.out_high_byte);
        errors++;
      end
      if (got.out_alpha !== want.out_alpha) begin
        $display("%0t: out_alpha expected %h actual %h", $time,
                 want.out_alpha, got.out_alpha);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  pixel_in_t in_pixel = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic busy;
  logic out_strobe;
  pixel_out_t out_pixel;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  colorize_scoreboard sb = new();
  int cycle_count = 0;

  pixel_colorize_hls_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_pixel(in_pixel),
    .out_strobe(out_strobe), .out_pixel(out_pixel),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("pixel_colorize_hls_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_pixel);
  end

  function automatic pixel_in_t make_px(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic [7:0] a);
    pixel_in_t px;
    px.in_red = r;
    px.in_green = g;
    px.in_blue = b;
    px.in_alpha = a;
    return px;
  endfunction

  function automatic logic [7:0] edge_level();
    logic [7:0] levels [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    return levels[$urandom_range(0, 5)];
  endfunction

  function automatic pixel_in_t random_px();
    int unsigned kind;
    logic [7:0] base;
    kind = $urandom_range(0, 99);
    base = 8'($urandom);
    if (kind < 60) return pixel_in_t'($urandom);
    if (kind < 75) return make_px(base, base, base, 8'($urandom));
    if (kind < 90) return make_px(edge_level(), edge_level(), edge_level(), 8'($urandom));
    // near grey: small spread around one level
    return make_px(base, base ^ 8'($urandom_range(0, 3)), base ^ 8'($urandom_range(0, 3)),
                   8'($urandom));
  endfunction

  function automatic int random_gap(bit bursty);
    int unsigned roll;
    if (bursty) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Hold the request until the block takes it.
  task automatic send_pixel(pixel_in_t px);
    start <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (busy);
    sb.note_request(px);
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (sb.expected_px_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic cfg_release();
    psel <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    pixel_in_t corner_px [12];
    logic [12:0] hue_tab [12] = '{13'd0, 13'd959, 13'd960, 13'd1920, 13'd2879, 13'd2880,
                                 13'd3839, 13'd3840, 13'd5759, 13'd5760, 13'd8191, 13'd4800};
    logic [8:0] sat_tab [12] = '{9'd256, 9'd0, 9'd1, 9'd511, 9'd257, 9'd128,
                                9'd255, 9'd0, 9'd256, 9'd64, 9'd300, 9'd200};
    logic [31:0] hue_val, sat_val, keep_val;
    bit bursty;

    corner_px[0] = make_px(8'd0, 8'd0, 8'd0, 8'd0);
    corner_px[1] = make_px(8'd255, 8'd255, 8'd255, 8'd255);
    corner_px[2] = make_px(8'd255, 8'd0, 8'd0, 8'd170);
    corner_px[3] = make_px(8'd0, 8'd255, 8'd0, 8'd85);
    corner_px[4] = make_px(8'd0, 8'd0, 8'd255, 8'd1);
    corner_px[5] = make_px(8'd127, 8'd127, 8'd127, 8'd128);
    corner_px[6] = make_px(8'd128, 8'd128, 8'd128, 8'd127);
    corner_px[7] = make_px(8'd255, 8'd1, 8'd1, 8'd254);
    corner_px[8] = make_px(8'd254, 8'd0, 8'd1, 8'd0);
    corner_px[9] = make_px(8'd255, 8'd255, 8'd0, 8'd255);
    corner_px[10] = make_px(8'd0, 8'd255, 8'd255, 8'd15);
    corner_px[11] = make_px(8'd1, 8'd0, 8'd0, 8'd240);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners under reset settings, then with saturation kept
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    wait_drain();
    cfg_write(REG_KEEP_SAT, 32'd1);
    cfg_release();
    foreach (corner_px[i]) send_pixel(corner_px[i] ^ 32'h5a000000);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drain();
      keep_val = ph % 2;
      hue_val = (ph < 12) ? hue_tab[ph] : $urandom_range(0, 8191);
      sat_val = (ph < 12) ? sat_tab[ph] : $urandom_range(0, 511);
      // junk above the register widths must be dropped
      if (ph % 3 == 2) begin
        keep_val[31:1] = 31'($urandom);
        hue_val[31:13] = 19'($urandom);
        sat_val[31:9] = 23'($urandom);
      end
      cfg_write(REG_KEEP_SAT, keep_val);
      cfg_write(REG_HUE, hue_val);
      cfg_write(REG_SAT, sat_val);
      if (ph == 5) cfg_write(REG_UNUSED, $urandom);
      cfg_release();
      bursty = (ph % 4 == 1);
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        send_pixel(random_px());
        if (!bursty && $urandom_range(0, 99) == 0) wait_drain();
        else pause_sender(random_gap(bursty));
      end
    end

    wait_drain();
    repeat (12) @(posedge clk);
    $display("Sent %0d pixels over %0d register settings in both modes;",
             sb.requests, PHASES + 2);
    $display("checked %0d results, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.expected_px_q.size() == 0) begin
      $display("pixel_colorize_hls_unit verification clean");
    end else begin
      $display("pixel_colorize_hls_unit verification failed");
    end
    $finish;
  end

endmodule
